FILE: sv/rse_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_pkg - shared types, constants and table builder
// Register codes, job layout between front and back, and the quarter-wave
// sine table that is swept into RAM after reset.
// ============================================================================
package rse_pkg;

   // Quarter-wave table: SINE_TABLE_DEPTH must be a power of two.
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int QTAB_LOG2        = $clog2(SINE_TABLE_DEPTH);
   localparam int QTAB_ENTRIES     = SINE_TABLE_DEPTH + 1;
   localparam int QTAB_ABITS       = $clog2(QTAB_ENTRIES);
   localparam int QTAB_WIDTH       = 15;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Winding offsets in volts times 256.
   localparam logic signed [15:0] SIN_OFFSET = 16'sd0;
   localparam logic signed [15:0] COS_OFFSET = 16'sd0;

   // Datapath widths.
   localparam int OUT_WIDTH  = 17;
   localparam int ACC_WIDTH  = 18;
   localparam int FAC_WIDTH  = 17;
   localparam int PROD_WIDTH = ACC_WIDTH + FAC_WIDTH;
   localparam int LANES      = 3;
   localparam int LOOKUPS    = 5;

   // Job queue between front and back.
   localparam int JOBQ_DEPTH = 2;
   localparam int JOBQ_PTR   = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT   = $clog2(JOBQ_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_WIDTH = 3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EXC_STEP   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROTOR_STEP = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EXC_AMP    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SIN_GAIN   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COS_GAIN   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SIN_SHIFT  = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COS_SHIFT  = 3'd6;

   localparam logic [31:0] RST_EXC_STEP   = 32'd214748365;
   localparam logic [31:0] RST_ROTOR_STEP = 32'd13671306;
   localparam logic [15:0] RST_EXC_AMP    = 16'd3840;
   localparam logic [15:0] RST_SIN_GAIN   = 16'd26214;
   localparam logic [15:0] RST_COS_GAIN   = 16'd26214;
   localparam logic [15:0] RST_SIN_SHIFT  = 16'd0;
   localparam logic [15:0] RST_COS_SHIFT  = 16'd0;

   typedef struct packed {
      logic [31:0] exc_phase_step;
      logic [31:0] rotor_phase_step;
      logic [15:0] exc_amplitude;
      logic [15:0] sin_gain;
      logic [15:0] cos_gain;
      logic [15:0] sin_phase_shift;
      logic [15:0] cos_phase_shift;
   } csr_type;

   typedef struct packed {
      logic [QTAB_ABITS-1:0] addr;
      logic                  neg;
   } lookup_type;

   // Lookup order: carrier, sine-shifted carrier, cosine-shifted carrier,
   // rotor sine, rotor cosine.
   typedef struct packed {
      lookup_type [LOOKUPS-1:0] look;
      logic [15:0]              rotor_angle;
   } job_type;

   typedef logic [QTAB_WIDTH-1:0] qtab_type [0:SINE_TABLE_DEPTH];

   // Map a phase onto a table address and a sign.
   function automatic lookup_type classify(input logic [31:0] phase);
      logic [1:0]            quad;
      logic [QTAB_LOG2-1:0]  frac;
      logic [QTAB_ABITS-1:0] base;
      lookup_type            res;
      quad     = phase[31:30];
      frac     = phase[29 -: QTAB_LOG2];
      base     = QTAB_ABITS'(SINE_TABLE_DEPTH);
      res.addr = quad[0] ? base - QTAB_ABITS'(frac) : QTAB_ABITS'(frac);
      res.neg  = quad[1];
      return res;
   endfunction

   // Taylor series in Q30 up to x^13, rounded to Q15.
   function automatic qtab_type build_qtab();
      qtab_type          tab;
      longint unsigned   x;
      longint unsigned   t;
      longint unsigned   r;
      longint            sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x   = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
         t   = x;
         sum = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (n)
               1: t = t / 64'd6;
               2: t = t / 64'd20;
               3: t = t / 64'd42;
               4: t = t / 64'd72;
               5: t = t / 64'd110;
               default: t = t / 64'd156;
            endcase
            if ((n & 1) == 1) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (longint'(unsigned'(sum)) + 64'd16384) >> 15;
         if (r > 64'd32767) begin
            r = 64'd32767;
         end
         tab[k] = QTAB_WIDTH'(r);
      end
      return tab;
   endfunction

   localparam qtab_type SINE_QTAB = build_qtab();

endpackage

FILE: sv/rse_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module rse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/rse_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_front - phase accumulators and lookup classification
// Accepts ticks, applies restart, forms the five table lookups of a sample.
// ============================================================================
module rse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             req_restart,
   output logic             full,
   input  rse_pkg::csr_type csr,
   input  logic             clearing,
   output logic             job_push,
   output rse_pkg::job_type job_data,
   input  logic             job_full
);
   import rse_pkg::*;

   logic [31:0] carrier_ff, carrier_in;
   logic [31:0] angle_ff, angle_in;
   logic [31:0] carrier_now, angle_now;
   logic        accept;

   assign full     = job_full | clearing;
   assign accept   = push & ~full;
   assign job_push = accept;

   always_comb begin
      carrier_now = req_restart ? '0 : carrier_ff;
      angle_now   = req_restart ? '0 : angle_ff;
      carrier_in  = carrier_ff;
      angle_in    = angle_ff;
      if (accept) begin
         carrier_in = carrier_now + csr.exc_phase_step;
         angle_in   = angle_now + csr.rotor_phase_step;
      end
      job_data.look[0]     = classify(carrier_now);
      job_data.look[1]     = classify(carrier_now + {csr.sin_phase_shift, 16'h0000});
      job_data.look[2]     = classify(carrier_now + {csr.cos_phase_shift, 16'h0000});
      job_data.look[3]     = classify(angle_now);
      job_data.look[4]     = classify(angle_now + 32'h4000_0000);
      job_data.rotor_angle = angle_now[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff <= '0;
         angle_ff   <= '0;
      end else begin
         carrier_ff <= carrier_in;
         angle_ff   <= angle_in;
      end
   end

endmodule

FILE: sv/rse_job_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_job_queue - short queue of classified jobs
// Decouples the front from the back so that each side stalls on its own.
// ============================================================================
module rse_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rse_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output rse_pkg::job_type pop_data
);
   import rse_pkg::*;

   job_type               slot_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOBQ_PTR-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOBQ_CNT-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == JOBQ_CNT'(JOBQ_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + JOBQ_CNT'(do_push) - JOBQ_CNT'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/rse_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_back - table sequencer and multiply lanes
// Fills the sine RAM after reset, then per job reads five table values and
// runs three multiply-and-round passes over three lanes before output.
// ============================================================================
module rse_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rse_pkg::csr_type                    csr,
   input  logic                                job_valid,
   input  rse_pkg::job_type                    job_data,
   output logic                                job_pop,
   output logic                                clearing,
   input  logic                                pop,
   output logic                                empty,
   output logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_excitation,
   output logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_sin_channel,
   output logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_cos_channel,
   output logic [15:0]                         rsp_rotor_angle
);
   import rse_pkg::*;

   localparam int LOOK_CNT_W = $clog2(LOOKUPS + 1);
   localparam logic [1:0] ROUND_AMP   = 2'd0;
   localparam logic [1:0] ROUND_ROTOR = 2'd1;
   localparam logic [1:0] ROUND_GAIN  = 2'd2;
   localparam logic signed [FAC_WIDTH-1:0] FAC_UNITY = 17'sd32768;
   localparam logic signed [15:0] EXC_OFFSET = 16'sd0;
   localparam logic signed [ACC_WIDTH:0] OUT_LIMIT = 19'sd65535;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK, ST_MUL, ST_RND, ST_PUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [QTAB_ABITS-1:0]        fill_ff, fill_in;
   logic [LOOK_CNT_W-1:0]        cnt_ff, cnt_in;
   logic [1:0]                   round_ff, round_in;
   job_type                      job_ff, job_in;
   logic signed [15:0]           val_ff [LOOKUPS];
   logic signed [15:0]           val_in [LOOKUPS];
   logic signed [ACC_WIDTH-1:0]  acc_ff [LANES];
   logic signed [ACC_WIDTH-1:0]  acc_in [LANES];
   logic signed [PROD_WIDTH-1:0] prod_ff [LANES];
   logic signed [PROD_WIDTH-1:0] prod_in [LANES];
   logic signed [FAC_WIDTH-1:0]  fac [LANES];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_WIDTH-1:0]  exc_ff, exc_in;
   logic signed [OUT_WIDTH-1:0]  sin_ff, sin_in;
   logic signed [OUT_WIDTH-1:0]  cos_ff, cos_in;
   logic [15:0]                  angle_ff, angle_in;
   logic [QTAB_ABITS-1:0]        rd_addr;
   logic [QTAB_WIDTH-1:0]        rd_data;
   logic signed [15:0]           rd_value;

   // Round a Q15 product to nearest, ties away from zero.
   function automatic logic signed [ACC_WIDTH-1:0] round_q15(
      input logic signed [PROD_WIDTH-1:0] p
   );
      logic [PROD_WIDTH-1:0] mag;
      logic [PROD_WIDTH-1:0] rnd;
      mag = p[PROD_WIDTH-1] ? PROD_WIDTH'(-p) : PROD_WIDTH'(p);
      rnd = (mag + PROD_WIDTH'(16384)) >> 15;
      return p[PROD_WIDTH-1] ? -(ACC_WIDTH'(rnd)) : ACC_WIDTH'(rnd);
   endfunction

   // Add the offset and saturate to the output range.
   function automatic logic signed [OUT_WIDTH-1:0] clamp_out(
      input logic signed [ACC_WIDTH-1:0] v,
      input logic signed [15:0]          off
   );
      logic signed [ACC_WIDTH:0] s;
      s = (ACC_WIDTH+1)'(v) + (ACC_WIDTH+1)'(off);
      if (s > OUT_LIMIT) begin
         return OUT_WIDTH'(OUT_LIMIT);
      end else if (s < -OUT_LIMIT) begin
         return OUT_WIDTH'(-OUT_LIMIT);
      end
      return OUT_WIDTH'(s);
   endfunction

   rse_ram #(
      .WIDTH (QTAB_WIDTH),
      .DEPTH (QTAB_ENTRIES)
   ) u_qtab (
      .clock   (clock),
      .wr_en   (state_ff == ST_CLEAR),
      .wr_addr (fill_ff),
      .wr_data (SINE_QTAB[fill_ff]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign clearing        = (state_ff == ST_CLEAR);
   assign empty           = ~rsp_valid_ff;
   assign rsp_excitation  = exc_ff;
   assign rsp_sin_channel = sin_ff;
   assign rsp_cos_channel = cos_ff;
   assign rsp_rotor_angle = angle_ff;
   assign rd_value        = {1'b0, rd_data};

   // Table address for the lookup in flight.
   always_comb begin
      rd_addr = '0;
      for (int i = 0; i < LOOKUPS; i++) begin
         if (cnt_ff == LOOK_CNT_W'(i)) begin
            rd_addr = job_ff.look[i].addr;
         end
      end
   end

   // Per-lane factor of the current pass.
   always_comb begin
      case (round_ff)
         ROUND_AMP: begin
            for (int j = 0; j < LANES; j++) begin
               fac[j] = FAC_WIDTH'({1'b0, csr.exc_amplitude});
            end
         end
         ROUND_ROTOR: begin
            fac[0] = FAC_UNITY;
            fac[1] = FAC_WIDTH'(val_ff[3]);
            fac[2] = FAC_WIDTH'(val_ff[4]);
         end
         default: begin
            fac[0] = FAC_UNITY;
            fac[1] = FAC_WIDTH'({1'b0, csr.sin_gain});
            fac[2] = FAC_WIDTH'({1'b0, csr.cos_gain});
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      round_in     = round_ff;
      job_in       = job_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      exc_in       = exc_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      angle_in     = angle_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            fill_in = fill_ff + 1'b1;
            if (fill_ff == QTAB_ABITS'(QTAB_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               cnt_in   = '0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cnt_in = cnt_ff + 1'b1;
            for (int i = 0; i < LOOKUPS; i++) begin
               if (cnt_ff == LOOK_CNT_W'(i + 1)) begin
                  val_in[i] = job_ff.look[i].neg ? -rd_value : rd_value;
               end
            end
            if (cnt_ff == LOOK_CNT_W'(LOOKUPS)) begin
               for (int j = 0; j < LANES; j++) begin
                  acc_in[j] = ACC_WIDTH'(val_ff[j]);
               end
               round_in = ROUND_AMP;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int j = 0; j < LANES; j++) begin
               prod_in[j] = acc_ff[j] * fac[j];
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            for (int j = 0; j < LANES; j++) begin
               acc_in[j] = round_q15(prod_ff[j]);
            end
            if (round_ff == ROUND_GAIN) begin
               state_in = ST_PUT;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_PUT: begin
            // Hold until the result slot is free or being taken.
            if (~rsp_valid_ff | pop) begin
               rsp_valid_in = 1'b1;
               exc_in       = clamp_out(acc_ff[0], EXC_OFFSET);
               sin_in       = clamp_out(acc_ff[1], SIN_OFFSET);
               cos_in       = clamp_out(acc_ff[2], COS_OFFSET);
               angle_in     = job_ff.rotor_angle;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      round_ff <= round_in;
      job_ff   <= job_in;
      val_ff   <= val_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      exc_ff   <= exc_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      angle_ff <= angle_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/resolver_signal_emulator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// resolver_signal_emulator_core - resolver excitation and secondary samples
// Each tick yields one sample of excitation, sine and cosine windings and
// the rotor angle, from two phase accumulators and a quarter-wave table.
// ============================================================================
//
//   channel   handshake             payload
//   --------  --------------------  ---------------------------------------
//   request   push / full           req_restart
//   response  empty / pop           rsp_excitation, rsp_sin_channel,
//                                   rsp_cos_channel, rsp_rotor_angle
//   csr       csr_wr_en             csr_index, csr_wdata
//
// In the back end a tick passes through taking the job, the five lookups through
// the single read port of the table RAM, the three multiply-and-round passes
// and the load of the result register.
// After reset the table RAM is filled with SINE_TABLE_DEPTH + 1 entries
// (1025 at the default depth); full stays high while it is filled.
// The job queue holds two ticks, so the front keeps accepting until the queue
// is full while the back works or while a result waits for pop.
//
module resolver_signal_emulator_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                push,
   output logic                                full,
   input  logic                                req_restart,
   // response channel
   output logic                                empty,
   input  logic                                pop,
   output logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_excitation,
   output logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_sin_channel,
   output logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_cos_channel,
   output logic [15:0]                         rsp_rotor_angle,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [rse_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                         csr_wdata
);
   import rse_pkg::*;

   csr_type csr_ff, csr_in;
   logic    job_push, job_full, job_valid, job_pop, clearing;
   job_type job_push_data, job_pop_data;

   // Register file: write-only, masked to each register's width;
   // drop writes to unused indexes.
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_EXC_STEP:   csr_in.exc_phase_step   = csr_wdata;
            CSR_ROTOR_STEP: csr_in.rotor_phase_step = csr_wdata;
            CSR_EXC_AMP:    csr_in.exc_amplitude    = csr_wdata[15:0];
            CSR_SIN_GAIN:   csr_in.sin_gain         = csr_wdata[15:0];
            CSR_COS_GAIN:   csr_in.cos_gain         = csr_wdata[15:0];
            CSR_SIN_SHIFT:  csr_in.sin_phase_shift  = csr_wdata[15:0];
            CSR_COS_SHIFT:  csr_in.cos_phase_shift  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.exc_phase_step   <= RST_EXC_STEP;
         csr_ff.rotor_phase_step <= RST_ROTOR_STEP;
         csr_ff.exc_amplitude    <= RST_EXC_AMP;
         csr_ff.sin_gain         <= RST_SIN_GAIN;
         csr_ff.cos_gain         <= RST_COS_GAIN;
         csr_ff.sin_phase_shift  <= RST_SIN_SHIFT;
         csr_ff.cos_phase_shift  <= RST_COS_SHIFT;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front: advance the phases and classify the lookups of each tick.
   rse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_restart (req_restart),
      .full        (full),
      .csr         (csr_ff),
      .clearing    (clearing),
      .job_push    (job_push),
      .job_data    (job_push_data),
      .job_full    (job_full)
   );

   // Queue between front and back.
   rse_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .pop_data  (job_pop_data)
   );

   // Back: table reads, multiply lanes, saturation and result register.
   rse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .job_valid       (job_valid),
      .job_data        (job_pop_data),
      .job_pop         (job_pop),
      .clearing        (clearing),
      .pop             (pop),
      .empty           (empty),
      .rsp_excitation  (rsp_excitation),
      .rsp_sin_channel (rsp_sin_channel),
      .rsp_cos_channel (rsp_cos_channel),
      .rsp_rotor_angle (rsp_rotor_angle)
   );

endmodule

FILE: sv/rse_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_checker - port-level checks for the resolver emulator
// Watches reset behaviour, result hold under stall and output saturation.
// ============================================================================
module rse_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                full,
   input logic                                empty,
   input logic                                pop,
   input logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_excitation,
   input logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_sin_channel,
   input logic signed [rse_pkg::OUT_WIDTH-1:0] rsp_cos_channel,
   input logic [15:0]                         rsp_rotor_angle
);
   import rse_pkg::*;

   localparam logic signed [OUT_WIDTH-1:0] NEG_RAIL = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   // Reset drops any pending result.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result pending after reset");

   // Table fill blocks new ticks straight after reset.
   a_reset_full: assert property (@(posedge clock) reset |=> full)
      else $error("tick accepted during table fill");

   // A stalled result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_excitation)
         && $stable(rsp_sin_channel) && $stable(rsp_cos_channel)
         && $stable(rsp_rotor_angle)))
      else $error("stalled result changed");

   // Windings saturate symmetrically.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_sin_channel != NEG_RAIL && rsp_cos_channel != NEG_RAIL))
      else $error("winding output beyond saturation limit");

   a_exc_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_excitation != NEG_RAIL))
      else $error("excitation beyond range");

endmodule

bind resolver_signal_emulator_core rse_checker u_rse_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the resolver signal emulator
// Drives ticks through the push/full queue port and checks every popped
// sample field by field against a bit-exact predictor of the phase
// accumulators, the quarter-wave sine table and the rounded Q15 products.
// Settings change only while the core is drained.
// ============================================================================
module tb_top;
   import rse_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE = 3'd7;   // no register here
   localparam longint OUT_LIMIT      = 65535;
   localparam int     MAX_REPORTS    = 40;
   localparam int     HOLD_OFF_TICKS = 90;
   localparam int     TAIL_CYCLES    = 40;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] excitation;
      logic signed [OUT_WIDTH-1:0] sin_channel;
      logic signed [OUT_WIDTH-1:0] cos_channel;
      logic [15:0]                 rotor_angle;
   } resolver_sample_type;

   logic                            clock;
   logic                            reset;
   logic                            push;
   logic                            full;
   logic                            req_restart;
   logic                            empty;
   logic                            pop;
   logic signed [OUT_WIDTH-1:0]     rsp_excitation;
   logic signed [OUT_WIDTH-1:0]     rsp_sin_channel;
   logic signed [OUT_WIDTH-1:0]     rsp_cos_channel;
   logic [15:0]                     rsp_rotor_angle;
   logic                            csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0]        csr_index;
   logic [31:0]                     csr_wdata;

   // Predictor state: register copy, both accumulators and the sine table.
   csr_type             settings;
   logic [31:0]         carrier_acc;
   logic [31:0]         angle_acc;
   longint              quarter_sine [0:SINE_TABLE_DEPTH];
   resolver_sample_type pending_samples [$];

   int  mismatch_count;
   bit  sender_gaps;
   bit  receiver_stalls;
   int  hold_off_cycles;
   int  rsp_stall_left;

   resolver_signal_emulator_core dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_restart     (req_restart),
      .empty           (empty),
      .pop             (pop),
      .rsp_excitation  (rsp_excitation),
      .rsp_sin_channel (rsp_sin_channel),
      .rsp_cos_channel (rsp_cos_channel),
      .rsp_rotor_angle (rsp_rotor_angle),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous ceiling on the whole run.
   initial begin
      #10ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Fill the quarter-wave table: odd Taylor terms to x^13 in Q30, rounded to Q15.
   task automatic fill_quarter_sine();
      longint unsigned x;
      longint unsigned term;
      longint unsigned rounded;
      longint          sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * longint'(k)) / longint'(SINE_TABLE_DEPTH);
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rounded = (longint'(sum) + 16384) >> 15;
         if (rounded > 32767) begin
            rounded = 32767;
         end
         quarter_sine[k] = longint'(rounded);
      end
   endtask

   // Signed Q15 sine of a 32-bit turn fraction, folded through the quadrants.
   function automatic longint table_sine(input logic [31:0] phase);
      longint unsigned idx;
      longint unsigned quad;
      longint unsigned rem;
      longint          mag;
      idx  = (64'(phase) * 64'(4 * SINE_TABLE_DEPTH)) >> 32;
      quad = (idx / SINE_TABLE_DEPTH) & 3;
      rem  = idx % SINE_TABLE_DEPTH;
      if (quad == 0 || quad == 2) begin
         mag = quarter_sine[rem];
      end else begin
         mag = quarter_sine[SINE_TABLE_DEPTH - rem];
      end
      return (quad >= 2) ? -mag : mag;
   endfunction

   // Product scaled down by 2^15, ties rounded away from zero.
   function automatic longint round_q15(input longint a, input longint b);
      longint          prod;
      longint unsigned mag;
      prod = a * b;
      mag  = (prod < 0) ? longint'(-prod) : longint'(prod);
      mag  = (mag + 16384) >> 15;
      return (prod < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp_output(input longint v);
      if (v > OUT_LIMIT) begin
         return OUT_LIMIT;
      end
      if (v < -OUT_LIMIT) begin
         return -OUT_LIMIT;
      end
      return v;
   endfunction

   function automatic longint winding_voltage(input logic [15:0] shift,
                                              input longint rotor_term,
                                              input logic [15:0] gain,
                                              input longint offset);
      logic [31:0] phase;
      longint      w;
      phase = carrier_acc + {shift, 16'h0000};
      w = round_q15(longint'(settings.exc_amplitude), table_sine(phase));
      w = round_q15(w, rotor_term);
      w = round_q15(w, longint'(gain));
      return clamp_output(w + offset);
   endfunction

   // Apply a requested restart, work out one sample from the current phases, then advance both accumulators.
   function automatic resolver_sample_type predict_sample(input logic restart_bit);
      resolver_sample_type s;
      longint              rotor_sin;
      longint              rotor_cos;
      longint              exc;
      if (restart_bit) begin
         carrier_acc = '0;
         angle_acc   = '0;
      end
      rotor_sin = table_sine(angle_acc);
      rotor_cos = table_sine(angle_acc + 32'h4000_0000);
      exc = round_q15(longint'(settings.exc_amplitude), table_sine(carrier_acc));
      s.excitation  = OUT_WIDTH'(exc);
      s.sin_channel = OUT_WIDTH'(winding_voltage(settings.sin_phase_shift, rotor_sin,
                                                 settings.sin_gain, longint'(SIN_OFFSET)));
      s.cos_channel = OUT_WIDTH'(winding_voltage(settings.cos_phase_shift, rotor_cos,
                                                 settings.cos_gain, longint'(COS_OFFSET)));
      s.rotor_angle = angle_acc[31:16];
      carrier_acc = carrier_acc + settings.exc_phase_step;
      angle_acc   = angle_acc + settings.rotor_phase_step;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // Compare every popped sample with the oldest prediction.
   always @(posedge clock) begin : check_samples
      resolver_sample_type want;
      if (!reset && pop && !empty) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("transfer with nothing pending", 1, 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_excitation !== want.excitation) begin
               report_mismatch("excitation", rsp_excitation, want.excitation);
            end
            if (rsp_sin_channel !== want.sin_channel) begin
               report_mismatch("sin_channel", rsp_sin_channel, want.sin_channel);
            end
            if (rsp_cos_channel !== want.cos_channel) begin
               report_mismatch("cos_channel", rsp_cos_channel, want.cos_channel);
            end
            if (rsp_rotor_angle !== want.rotor_angle) begin
               report_mismatch("rotor_angle", rsp_rotor_angle, want.rotor_angle);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off when one is requested
   // ------------------------------------------------------------------------
   initial begin
      pop <= 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            // Hold pop low for the whole stretch, counted here.
            pop <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            if (rsp_stall_left == 0 && receiver_stalls && $urandom_range(0, 9) == 0) begin
               rsp_stall_left = $urandom_range(1, 12);
            end
            if (rsp_stall_left != 0) begin
               pop <= 1'b0;
               rsp_stall_left--;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender and register port
   // ------------------------------------------------------------------------

   // Offer one tick, hold it until the transfer, then record its prediction.
   task automatic push_tick(input logic restart_bit);
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      push        <= 1'b1;
      req_restart <= restart_bit;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_samples.push_back(predict_sample(restart_bit));
   endtask

   // Drop push and wait until every predicted sample has been popped.
   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (pending_samples.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_WIDTH-1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_EXC_STEP:   settings.exc_phase_step   = data;
         CSR_ROTOR_STEP: settings.rotor_phase_step = data;
         CSR_EXC_AMP:    settings.exc_amplitude    = data[15:0];
         CSR_SIN_GAIN:   settings.sin_gain         = data[15:0];
         CSR_COS_GAIN:   settings.cos_gain         = data[15:0];
         CSR_SIN_SHIFT:  settings.sin_phase_shift  = data[15:0];
         CSR_COS_SHIFT:  settings.cos_phase_shift  = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_setting();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'(32768);
         3: return 32'($urandom_range(0, 32768));
         default: return $urandom;
      endcase
   endfunction

   task automatic write_random_settings();
      for (int i = 0; i <= int'(CSR_COS_SHIFT); i++) begin
         csr_write(CSR_IDX_WIDTH'(i), pick_setting());
      end
      if ($urandom_range(0, 3) == 0) begin
         csr_write(CSR_SPARE, $urandom);
      end
   endtask

   task automatic push_random_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         push_tick($urandom_range(0, 15) == 0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings, first sample from the cleared phases, then a restart mid-run.
   task automatic test_power_on_defaults();
      repeat (4) push_tick(1'b0);
      push_tick(1'b1);
      repeat (2) push_tick(1'b0);
   endtask

   // Quarter- and eighth-turn steps land on every quadrant boundary; full sine gain saturates.
   task automatic test_quadrants_and_saturation();
      wait_drained();
      csr_write(CSR_EXC_STEP,   32'h4000_0000);
      csr_write(CSR_ROTOR_STEP, 32'h2000_0000);
      csr_write(CSR_EXC_AMP,    32'h0000_FFFF);
      csr_write(CSR_SIN_GAIN,   32'h0000_FFFF);
      csr_write(CSR_COS_GAIN,   32'h0000_8000);
      csr_write(CSR_SIN_SHIFT,  32'h0000_4000);
      csr_write(CSR_COS_SHIFT,  32'h0000_C000);
      push_tick(1'b1);
      repeat (7) push_tick(1'b0);
   endtask

   // Upper data bits must be dropped on narrow registers; the spare index is ignored.
   task automatic test_masking_and_spare_index();
      wait_drained();
      csr_write(CSR_EXC_STEP,   32'hFFFF_FFFF);
      csr_write(CSR_ROTOR_STEP, 32'hFFFF_FFFF);
      csr_write(CSR_EXC_AMP,    32'hABCD_FFFF);
      csr_write(CSR_SIN_GAIN,   32'hFFFF_0000);
      csr_write(CSR_COS_GAIN,   32'h1234_8000);
      csr_write(CSR_SIN_SHIFT,  32'hFFFF_FFFF);
      csr_write(CSR_COS_SHIFT,  32'h0001_0000);
      csr_write(CSR_SPARE,      32'hFFFF_FFFF);
      push_tick(1'b1);
      repeat (4) push_tick(1'b0);
   endtask

   // Stop popping for a long stretch while ticks keep coming, so full rises.
   task automatic test_receiver_hold_off();
      bit keep_gaps;
      keep_gaps = sender_gaps;
      wait_drained();
      sender_gaps     = 1'b0;
      hold_off_cycles = HOLD_OFF_TICKS;
      push_random_ticks(12);
      wait_drained();
      sender_gaps = keep_gaps;
   endtask

   task automatic test_random_settings(input int phases, input int ticks_per_phase);
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         write_random_settings();
         push_random_ticks(ticks_per_phase);
      end
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_steady_stream(input int ticks);
      wait_drained();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      write_random_settings();
      push_random_ticks(ticks);
   endtask

   initial begin
      reset       <= 1'b1;
      push        <= 1'b0;
      req_restart <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      mismatch_count  = 0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      hold_off_cycles = 0;
      carrier_acc     = '0;
      angle_acc       = '0;
      settings.exc_phase_step   = RST_EXC_STEP;
      settings.rotor_phase_step = RST_ROTOR_STEP;
      settings.exc_amplitude    = RST_EXC_AMP;
      settings.sin_gain         = RST_SIN_GAIN;
      settings.cos_gain         = RST_COS_GAIN;
      settings.sin_phase_shift  = RST_SIN_SHIFT;
      settings.cos_phase_shift  = RST_COS_SHIFT;
      fill_quarter_sine();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The table sweep after reset keeps full high; the first tick waits on it.
      test_power_on_defaults();
      test_quadrants_and_saturation();
      test_masking_and_spare_index();
      test_receiver_hold_off();
      test_random_settings(5, 240);
      test_steady_stream(300);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: resolver_signal_emulator_core.f
sv/rse_pkg.sv
sv/rse_ram.sv
sv/rse_front.sv
sv/rse_job_queue.sv
sv/rse_back.sv
sv/resolver_signal_emulator_core.sv
sv/rse_checker.sv
tb/sv/tb_top.sv
